// File: hw/rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell writer package
// Shared sizes, codes and the command and status structs that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int CELLS    = COLUMNS * ROWS;
   localparam int TAB_STOP = 8;

   localparam int MODE_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int IDX_W     = 11;
   localparam int CELL_W    = 16;
   localparam int ATTR_W    = 8;
   localparam int OUT_ROW_W = 5;
   localparam int OUT_COL_W = 7;

   localparam int ADDR_W = $clog2(CELLS);
   localparam int SUM_W  = $clog2(2 * CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int RT_W   = $clog2(ROWS + 1);
   localparam int CT_W   = $clog2(COLUMNS + TAB_STOP);

   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
   localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, CH_BLANK};

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHAR,
      ST_SCROLL,
      ST_CLEAR,
      ST_READ,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic do_char;
      logic scroll_start;
      logic clear_start;
      logic sweep_write;
      logic use_reset_blank;
      logic scroll_end;
      logic clear_end;
      logic do_read;
      logic capture_read;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scroll_needed;
      logic sweep_last;
   } ctrl_status_type;

endpackage

// File: hw/rtl/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console cell writer controller
// Sequences the reset clearing pass, character steps, scrolls, screen clears
// and cell reads, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module tccw_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tccw_pkg::MODE_W-1:0]   req_mode,
   input  tccw_pkg::ctrl_status_type     status,
   output tccw_pkg::ctrl_cmd_type        cmd,
   output logic                          busy,
   output logic                          rsp_valid
);
   import tccw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               case (req_mode)
                  MODE_PUT:   state_in = ST_CHAR;
                  MODE_CLEAR: state_in = ST_CLEAR;
                  MODE_READ:  state_in = ST_READ;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_CHAR: begin
            state_in = status.scroll_needed ? ST_SCROLL : ST_DONE;
         end
         ST_SCROLL: begin
            if (status.sweep_last) state_in = ST_DONE;
         end
         ST_CLEAR: begin
            if (status.sweep_last) state_in = ST_DONE;
         end
         ST_READ:      state_in = ST_READ_WAIT;
         ST_READ_WAIT: state_in = ST_DONE;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep_write     = 1'b1;
            cmd.use_reset_blank = 1'b1;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept      = 1'b1;
               cmd.clear_start = (req_mode == MODE_CLEAR);
            end
         end
         ST_CHAR: begin
            cmd.do_char      = 1'b1;
            cmd.scroll_start = status.scroll_needed;
         end
         ST_SCROLL: begin
            cmd.sweep_write = 1'b1;
            cmd.scroll_end  = status.sweep_last;
         end
         ST_CLEAR: begin
            cmd.sweep_write = 1'b1;
            cmd.clear_end   = status.sweep_last;
         end
         ST_READ:      cmd.do_read      = 1'b1;
         ST_READ_WAIT: cmd.capture_read = 1'b1;
         ST_DONE:      rsp_valid        = 1'b1;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: hw/rtl/tccw_datapath.sv
// ----------------------------------------------------------------------------
// Text console cell writer datapath
// Holds the screen store, the cursor, the rotating row base, the attribute
// register, the fill sweep counter and the result registers.
// ----------------------------------------------------------------------------
module tccw_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  tccw_pkg::ctrl_cmd_type         cmd,
   output tccw_pkg::ctrl_status_type      status,
   input  logic                           csr_write,
   input  logic [tccw_pkg::ATTR_W-1:0]    csr_attribute,
   input  logic [tccw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tccw_pkg::IDX_W-1:0]     req_cell_index,
   output logic [tccw_pkg::OUT_ROW_W-1:0] rsp_cursor_row,
   output logic [tccw_pkg::OUT_COL_W-1:0] rsp_cursor_col,
   output logic                           rsp_scrolled,
   output logic                           rsp_write_valid,
   output logic [tccw_pkg::IDX_W-1:0]     rsp_touched_index,
   output logic [tccw_pkg::CELL_W-1:0]    rsp_cell_value
);
   import tccw_pkg::*;

   logic [CELL_W-1:0] screen_mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   logic [ATTR_W-1:0] attr_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [ADDR_W-1:0] sweep_ptr_ff;
   logic [ADDR_W-1:0] sweep_cnt_ff;
   logic              sweep_row_ff;

   logic [CHAR_W-1:0] char_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic              scrolled_ff;
   logic              wrote_ff;
   logic [IDX_W-1:0]  touched_ff;
   logic [CELL_W-1:0] value_ff;

   logic [CELL_W-1:0] blank_cell;
   logic [CT_W-1:0]   col_t;
   logic [RT_W-1:0]   row_t;
   logic              char_writes;
   logic [COL_W-1:0]  wr_col;
   logic [CELL_W-1:0] char_value;
   logic              char_scroll;
   logic [ROW_W-1:0]  next_row;
   logic [COL_W-1:0]  next_col;
   logic [SUM_W-1:0]  logical_sum;
   logic [SUM_W-1:0]  wr_sum;
   logic [ADDR_W-1:0] wr_addr;
   logic [SUM_W-1:0]  rd_sum;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_in_range;
   logic [SUM_W-1:0]  base_next;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;

   assign blank_cell = {attr_ff, CH_BLANK};

   always_comb begin
      col_t       = CT_W'(col_ff);
      row_t       = RT_W'(row_ff);
      char_writes = 1'b0;
      wr_col      = col_ff;
      char_value  = {attr_ff, char_ff};
      case (char_ff)
         CH_LF: begin
            col_t = '0;
            row_t = row_t + RT_W'(1);
         end
         CH_CR: begin
            col_t = '0;
         end
         CH_BS: begin
            char_value = blank_cell;
            if (col_ff != '0) begin
               wr_col      = col_ff - COL_W'(1);
               col_t       = CT_W'(wr_col);
               char_writes = 1'b1;
            end
         end
         CH_TAB: begin
            col_t = (col_t + CT_W'(TAB_STOP)) & ~CT_W'(TAB_STOP - 1);
         end
         default: begin
            char_writes = 1'b1;
            col_t       = col_t + CT_W'(1);
         end
      endcase
      if (col_t >= CT_W'(COLUMNS)) begin
         col_t = '0;
         row_t = row_t + RT_W'(1);
      end
      char_scroll = (row_t >= RT_W'(ROWS));
      next_row    = char_scroll ? ROW_W'(ROWS - 1) : ROW_W'(row_t);
      next_col    = COL_W'(col_t);
   end

   always_comb begin
      logical_sum = SUM_W'(row_ff) * SUM_W'(COLUMNS) + SUM_W'(wr_col);
      wr_sum      = logical_sum + SUM_W'(base_ff);
      if (wr_sum >= SUM_W'(CELLS)) wr_sum = wr_sum - SUM_W'(CELLS);
      wr_addr     = ADDR_W'(wr_sum);

      rd_in_range = (SUM_W'(idx_ff) < SUM_W'(CELLS));
      rd_sum      = SUM_W'(idx_ff) + SUM_W'(base_ff);
      if (rd_sum >= SUM_W'(CELLS)) rd_sum = rd_sum - SUM_W'(CELLS);
      rd_addr     = ADDR_W'(rd_sum);

      base_next = SUM_W'(base_ff) + SUM_W'(COLUMNS);
      if (base_next >= SUM_W'(CELLS)) base_next = '0;
   end

   assign status.scroll_needed = char_scroll;
   assign status.sweep_last    = sweep_row_ff ? (sweep_cnt_ff == ADDR_W'(COLUMNS - 1))
                                              : (sweep_cnt_ff == ADDR_W'(CELLS - 1));

   assign mem_we    = (cmd.do_char && char_writes) || cmd.sweep_write;
   assign mem_waddr = cmd.sweep_write ? sweep_ptr_ff : wr_addr;
   assign mem_wdata = cmd.sweep_write ? (cmd.use_reset_blank ? RESET_CELL : blank_cell)
                                      : char_value;

   always_ff @(posedge clock) begin
      if (mem_we) screen_mem[mem_waddr] <= mem_wdata;
      if (cmd.do_read) rd_data_ff <= screen_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         sweep_ptr_ff <= '0;
         sweep_cnt_ff <= '0;
         sweep_row_ff <= 1'b0;
      end else begin
         if (csr_write) attr_ff <= csr_attribute;
         if (cmd.do_char) begin
            row_ff <= next_row;
            col_ff <= next_col;
         end
         if (cmd.scroll_end) base_ff <= ADDR_W'(base_next);
         if (cmd.clear_end) begin
            base_ff <= '0;
            row_ff  <= '0;
            col_ff  <= '0;
         end
         if (cmd.scroll_start) begin
            sweep_ptr_ff <= base_ff;
            sweep_cnt_ff <= '0;
            sweep_row_ff <= 1'b1;
         end else if (cmd.clear_start) begin
            sweep_ptr_ff <= '0;
            sweep_cnt_ff <= '0;
            sweep_row_ff <= 1'b0;
         end else if (cmd.sweep_write) begin
            sweep_ptr_ff <= sweep_ptr_ff + ADDR_W'(1);
            sweep_cnt_ff <= sweep_cnt_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff     <= req_char_code;
         idx_ff      <= req_cell_index;
         scrolled_ff <= 1'b0;
         wrote_ff    <= 1'b0;
         touched_ff  <= '0;
         value_ff    <= '0;
      end
      if (cmd.do_char) begin
         scrolled_ff <= char_scroll;
         wrote_ff    <= char_writes;
         touched_ff  <= char_writes ? IDX_W'(logical_sum) : '0;
         value_ff    <= char_writes ? char_value : '0;
      end
      if (cmd.capture_read) begin
         touched_ff <= idx_ff;
         value_ff   <= rd_in_range ? rd_data_ff : '0;
      end
   end

   assign rsp_cursor_row    = OUT_ROW_W'(row_ff);
   assign rsp_cursor_col    = OUT_COL_W'(col_ff);
   assign rsp_scrolled      = scrolled_ff;
   assign rsp_write_valid   = wrote_ff;
   assign rsp_touched_index = touched_ff;
   assign rsp_cell_value    = value_ff;

endmodule

// File: hw/rtl/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// Text console cell writer
// An 80 by 25 character-cell screen store with a cursor, driven by commands.
//
// A command is taken when start is high and busy is low: req_mode selects
// put character, clear screen or read one cell, with req_char_code and
// req_cell_index as its operands. Each command gives one result, shown on
// the rsp_ ports for one cycle while rsp_valid is high; the receiver cannot
// stall, and the block holds busy high until that cycle has passed.
// A plain character or control code passes through the character step to the
// result beat, a read through a read step and a read wait step. A character
// that scrolls the screen adds a sweep over the cells of the blanked row,
// since scrolling only rotates the row base and the single write port of the
// store blanks one cell a cycle. A clear sweeps the store the same way. After
// reset the store is swept to blanks with attribute 7, one cell a cycle, with
// busy high. The attribute register is written via the always ready csr_
// channel; write it only while no command is open: the block does not enforce.
// ----------------------------------------------------------------------------
module text_console_cell_writer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tccw_pkg::MODE_W-1:0]    req_mode,
   input  logic [tccw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tccw_pkg::IDX_W-1:0]     req_cell_index,
   output logic                           rsp_valid,
   output logic [tccw_pkg::OUT_ROW_W-1:0] rsp_cursor_row,
   output logic [tccw_pkg::OUT_COL_W-1:0] rsp_cursor_col,
   output logic                           rsp_scrolled,
   output logic                           rsp_write_valid,
   output logic [tccw_pkg::IDX_W-1:0]     rsp_touched_index,
   output logic [tccw_pkg::CELL_W-1:0]    rsp_cell_value,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tccw_pkg::ATTR_W-1:0]    csr_attribute
);
   import tccw_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tccw_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_valid && csr_ready),
      .csr_attribute     (csr_attribute),
      .req_char_code     (req_char_code),
      .req_cell_index    (req_cell_index),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_scrolled      (rsp_scrolled),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_touched_index (rsp_touched_index),
      .rsp_cell_value    (rsp_cell_value)
   );

endmodule
